/* sv/rmv_pkg.sv */
`timescale 1ns / 1ps
// rmv_pkg: widths, word types, command/status structs and codes for the running statistics block
package rmv_pkg;

    // field widths
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int COUNT_BITS  = 24;

    // datapath widths
    localparam int MEAN_W    = SAMPLE_BITS + FRAC_BITS;   // scaled sample and mean
    localparam int DIFF_W    = MEAN_W + 1;                // sample minus mean
    localparam int PROD_W    = 2 * MEAN_W + 1;            // product of two difference magnitudes
    localparam int M2_W      = PROD_W - FRAC_BITS;        // product after fraction shift
    localparam int VAR_W     = 48;                        // variance accumulator
    localparam int VAR_OUT_W = 47;                        // variance as delivered
    localparam int VDIFF_W   = M2_W + 1;                  // m2 minus variance, signed

    // shared divider: two quotient bits per cycle
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITERS = (VDIFF_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIVD_W    = DIV_ITERS * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);
    localparam int REM_W     = COUNT_BITS + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // divider operand select
    localparam logic DIV_SEL_MEAN = 1'b0;
    localparam logic DIV_SEL_VAR  = 1'b1;

    typedef struct packed {
        logic    operation;
        t_sample sample;
    } t_in_word;

    typedef struct packed {
        logic                       empty_res;
        logic                       refused;
        logic [COUNT_BITS-1:0]      sample_count;
        logic signed [MEAN_W-1:0]   mean_value;
        logic [VAR_OUT_W-1:0]       variance_value;
        t_sample                    minimum;
        t_sample                    maximum;
        t_sample                    last_sample;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch sample, n and first difference
        logic clear;       // statistics back to empty
        logic refuse;      // count saturated, sample dropped
        logic div_start;
        logic div_sel;
        logic mean_upd;
        logic d2_cap;
        logic mag_cap;
        logic mul_lo;
        logic mul_hi;
        logic var_diff;
        logic var_upd;     // variance update and commit of count/min/max/last
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic div_done;
    } t_sts;

endpackage

/* sv/running_mean_variance_minmax.sv */
`timescale 1ns / 1ps
// running_mean_variance_minmax: top level of the running mean/variance/min/max block
//
// input channel: i_in_valid / o_in_stall carry one word (operation, sample); a word is
//   taken at a rising edge with valid high and stall low. operation 1 clears the
//   statistics, 0 adds the sample (dropped and flagged refused once the count is full)
// output channel: o_out_valid / i_out_stall carry one result word per input word, a
//   snapshot of count, mean, variance, min, max and last sample after that word
// schedule: an added sample runs through the mean division, the d2 and magnitude steps,
//   a split 33x33 multiply (low partial product, then top-bit corrections), the variance
//   difference and the variance division; the two divisions by the running count share
//   one divider retiring 2 quotient bits a cycle. clear and refused words go straight to
//   the result step. one word is worked on at a time: the next word is accepted only
//   once the previous one has been loaded into the output register
// the result sits in an output register: the next word is accepted while the
//   previous result still waits; a stalled receiver only holds the block in its last
//   step when a new result is ready and the register is still full
// reset (i_rst_n low, synchronous) empties the statistics: count, mean, variance and
//   last sample zero, minimum at the largest and maximum at the smallest sample value
module running_mean_variance_minmax
    import rmv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    // command and status between sequencer and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    rmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_word.operation),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // statistics, divider, multiplier and result word register
    rmv_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_in_word.sample),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_word (o_out_word)
    );

endmodule

/* sv/rmv_div.sv */
`timescale 1ns / 1ps
// rmv_div: iterative unsigned restoring divider, two quotient bits per cycle
module rmv_div
    import rmv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVD_W-1:0]     i_dividend,
    input  logic [COUNT_BITS-1:0] i_divisor,
    output logic                  o_done,
    output logic [DIVD_W-1:0]     o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]      r_rem;
    logic [DIVD_W-1:0]     r_quot;
    logic [COUNT_BITS-1:0] r_den;
    logic [REM_W-1:0]      n_rem;
    logic [DIVD_W-1:0]     n_quot;

    // dividend bits shift out the top of r_quot while quotient bits enter at the bottom
    always_comb begin
        n_rem  = r_rem;
        n_quot = r_quot;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_rem  = {n_rem[REM_W-2:0], n_quot[DIVD_W-1]};
            n_quot = {n_quot[DIVD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem     = n_rem - {1'b0, r_den};
                n_quot[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_ITERS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_den  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* sv/rmv_datapath.sv */
`timescale 1ns / 1ps
// rmv_datapath: statistics registers, difference/multiply path, shared divider and result register
module rmv_datapath
    import rmv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sample   i_sample,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_word o_out_word
);

    // statistics
    logic signed [MEAN_W-1:0]  r_mean;
    logic [VAR_W-1:0]          r_var;
    t_sample                   r_min;
    t_sample                   r_max;
    t_sample                   r_last;
    logic [COUNT_BITS-1:0]     r_count;
    logic                      r_refused;

    // working registers for one sample
    t_sample                   r_s;
    logic [COUNT_BITS-1:0]     r_n;
    logic [DIFF_W-1:0]         r_d1;
    logic [DIFF_W-1:0]         r_d2;
    logic [DIFF_W-1:0]         r_amag;
    logic [DIFF_W-1:0]         r_bmag;
    logic                      r_neg;
    logic [2*MEAN_W-1:0]       r_plo;
    logic [M2_W-1:0]           r_m2mag;
    logic [VDIFF_W-1:0]        r_vd;
    t_out_word                 r_out;

    logic [MEAN_W-1:0]         w_scaled_in;
    logic [MEAN_W-1:0]         w_scaled;
    logic [DIFF_W-1:0]         w_d1_mag;
    logic [DIFF_W-1:0]         w_d2_mag;
    logic [VDIFF_W-1:0]        w_vd_mag;
    logic [DIVD_W-1:0]         w_div_dividend;
    logic                      w_div_done;
    logic [DIVD_W-1:0]         w_quot;
    logic [DIFF_W-1:0]         w_q_mean;
    logic [MEAN_W+1:0]         w_mean_sum;
    logic [MEAN_W-1:0]         w_mean_next;
    logic [PROD_W-1:0]         w_prod;
    logic [VDIFF_W-1:0]        w_m2s;
    logic [DIVD_W+1:0]         w_var_sum;
    logic [VAR_W-1:0]          w_var_next;

    // sample scaled to the mean's fixed point
    assign w_scaled_in = {{FRAC_BITS{i_sample[SAMPLE_BITS-1]}}, i_sample} << FRAC_BITS;
    assign w_scaled    = {{FRAC_BITS{r_s[SAMPLE_BITS-1]}}, r_s} << FRAC_BITS;

    assign w_d1_mag = r_d1[DIFF_W-1] ? (DIFF_W'(0) - r_d1) : r_d1;
    assign w_d2_mag = r_d2[DIFF_W-1] ? (DIFF_W'(0) - r_d2) : r_d2;
    assign w_vd_mag = r_vd[VDIFF_W-1] ? (VDIFF_W'(0) - r_vd) : r_vd;

    assign w_div_dividend = (i_cmd.div_sel == DIV_SEL_VAR) ? DIVD_W'(w_vd_mag)
                                                           : DIVD_W'(w_d1_mag);

    rmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // mean + d1/n, signed quotient, saturated to the mean's range
    assign w_q_mean   = w_quot[DIFF_W-1:0];
    assign w_mean_sum = {{2{r_mean[MEAN_W-1]}}, r_mean}
                      + (r_d1[DIFF_W-1] ? ((MEAN_W+2)'(0) - (MEAN_W+2)'(w_q_mean))
                                        : (MEAN_W+2)'(w_q_mean));

    always_comb begin
        if (w_mean_sum[MEAN_W+1:MEAN_W-1] == 3'b000 ||
            w_mean_sum[MEAN_W+1:MEAN_W-1] == 3'b111) begin
            w_mean_next = w_mean_sum[MEAN_W-1:0];
        end else if (w_mean_sum[MEAN_W+1]) begin
            w_mean_next = {1'b1, {(MEAN_W-1){1'b0}}};
        end else begin
            w_mean_next = {1'b0, {(MEAN_W-1){1'b1}}};
        end
    end

    // full product from the low partial product and the top-bit corrections
    assign w_prod = PROD_W'(r_plo)
                  + (r_amag[MEAN_W] ? (PROD_W'(r_bmag[MEAN_W-1:0]) << MEAN_W) : '0)
                  + (r_bmag[MEAN_W] ? (PROD_W'(r_amag[MEAN_W-1:0]) << MEAN_W) : '0)
                  + ((r_amag[MEAN_W] & r_bmag[MEAN_W]) ? (PROD_W'(1) << (2 * MEAN_W)) : '0);

    assign w_m2s = r_neg ? (VDIFF_W'(0) - VDIFF_W'(r_m2mag)) : VDIFF_W'(r_m2mag);

    // var + (m2 - var)/n, zero for the first sample, clamped at zero and at the accumulator width
    assign w_var_sum = (DIVD_W+2)'(r_var)
                     + (r_vd[VDIFF_W-1] ? ((DIVD_W+2)'(0) - (DIVD_W+2)'(w_quot))
                                        : (DIVD_W+2)'(w_quot));

    always_comb begin
        if (r_n == COUNT_BITS'(1) || w_var_sum[DIVD_W+1]) begin
            w_var_next = '0;
        end else if (w_var_sum[DIVD_W:VAR_W] != '0) begin
            w_var_next = '1;
        end else begin
            w_var_next = w_var_sum[VAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_mean    <= '0;
            r_var     <= '0;
            r_min     <= SAMPLE_MAX;
            r_max     <= SAMPLE_MIN;
            r_last    <= '0;
            r_count   <= '0;
            r_refused <= 1'b0;
        end else begin
            if (i_cmd.refuse) begin
                r_refused <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_refused <= 1'b0;
            end
            if (i_cmd.mean_upd) begin
                r_mean <= w_mean_next;
            end
            if (i_cmd.var_upd) begin
                r_var   <= w_var_next;
                r_count <= r_n;
                r_last  <= r_s;
                if (r_s < r_min) begin
                    r_min <= r_s;
                end
                if (r_s > r_max) begin
                    r_max <= r_s;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_s  <= i_sample;
            r_n  <= r_count + 1'b1;
            r_d1 <= {w_scaled_in[MEAN_W-1], w_scaled_in} - {r_mean[MEAN_W-1], r_mean};
        end
        if (i_cmd.d2_cap) begin
            r_d2   <= {w_scaled[MEAN_W-1], w_scaled} - {r_mean[MEAN_W-1], r_mean};
            r_amag <= w_d1_mag;
        end
        if (i_cmd.mag_cap) begin
            r_bmag <= w_d2_mag;
            r_neg  <= r_d1[DIFF_W-1] ^ r_d2[DIFF_W-1];
        end
        if (i_cmd.mul_lo) begin
            r_plo <= r_amag[MEAN_W-1:0] * r_bmag[MEAN_W-1:0];
        end
        if (i_cmd.mul_hi) begin
            r_m2mag <= w_prod[PROD_W-1:FRAC_BITS];
        end
        if (i_cmd.var_diff) begin
            r_vd <= w_m2s - VDIFF_W'(r_var);
        end
        if (i_cmd.load_out) begin
            r_out.empty_res      <= (r_count == '0);
            r_out.refused        <= r_refused;
            r_out.sample_count   <= r_count;
            r_out.mean_value     <= r_mean;
            r_out.variance_value <= r_var[VAR_W-1] ? '1 : r_var[VAR_OUT_W-1:0];
            r_out.minimum        <= r_min;
            r_out.maximum        <= r_max;
            r_out.last_sample    <= r_last;
        end
    end

    assign o_sts.full     = &r_count;
    assign o_sts.div_done = w_div_done;
    assign o_out_word     = r_out;

`ifndef SYNTHESIS
    // the mean moves ahead of the count on the first sample, so only variance is checked
    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_var == '0))
        else $error("empty statistics hold a nonzero variance");

    a_single_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == COUNT_BITS'(1)) |-> (r_var == '0))
        else $error("variance nonzero after one sample");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max && r_last >= r_min && r_last <= r_max))
        else $error("last sample outside min/max range");
`endif

endmodule

/* sv/rmv_ctrl.sv */
`timescale 1ns / 1ps
// rmv_ctrl: sequencer for one word at a time, drives datapath commands and output valid
module rmv_ctrl
    import rmv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_op,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1_START,
        ST_DIV1_WAIT,
        ST_D2,
        ST_MAG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_VAR_DIFF,
        ST_DIV2_START,
        ST_DIV2_WAIT,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_CLEAR) begin
                        w_cmd.clear = 1'b1;
                        n_state     = ST_DONE;
                    end else if (i_sts.full) begin
                        w_cmd.refuse = 1'b1;
                        n_state      = ST_DONE;
                    end else begin
                        w_cmd.capture = 1'b1;
                        n_state       = ST_DIV1_START;
                    end
                end
            end
            ST_DIV1_START: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_SEL_MEAN;
                n_state         = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.mean_upd = 1'b1;
                    n_state        = ST_D2;
                end
            end
            ST_D2: begin
                w_cmd.d2_cap = 1'b1;
                n_state      = ST_MAG;
            end
            ST_MAG: begin
                w_cmd.mag_cap = 1'b1;
                n_state       = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                w_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                w_cmd.mul_hi = 1'b1;
                n_state      = ST_VAR_DIFF;
            end
            ST_VAR_DIFF: begin
                w_cmd.var_diff = 1'b1;
                n_state        = ST_DIV2_START;
            end
            ST_DIV2_START: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_SEL_VAR;
                n_state         = ST_DIV2_WAIT;
            end
            ST_DIV2_WAIT: begin
                if (i_sts.div_done) begin
                    w_cmd.var_upd = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_DONE: begin
                // result register free or being emptied this cycle
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`ifndef SYNTHESIS
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV1_WAIT || r_state == ST_DIV2_WAIT))
        else $error("divider finished outside a wait state");

    a_clear_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_op == OP_CLEAR) |=> (r_state == ST_DONE))
        else $error("clear word did not go straight to result");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result valid raised outside the done state");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking testbench for the running mean/variance/min/max block
module tb;
    import rmv_pkg::*;

    // run shape
    localparam int LONG_HOLD      = 400;    // receiver hold-off, long enough to back up the input
    localparam int WATCHDOG_LIMIT = 4000;   // cycles without any accepted word
    localparam int SETTLE_CYCLES  = 100;    // quiet time after the last result
    localparam int MAX_REPORTS    = 10;

    // predictor bounds, at the block's widths
    localparam longint COUNT_FULL    = (64'sd1 <<< COUNT_BITS) - 1;
    localparam longint VAR_STATE_LIM = (64'sd1 <<< VAR_W) - 1;
    localparam longint VAR_OUT_LIM   = (64'sd1 <<< VAR_OUT_W) - 1;
    localparam longint MEAN_HI       = 64'sd2147483647;
    localparam longint MEAN_LO       = -64'sd2147483648;
    localparam logic [127:0] PRODUCT_CAP = 128'd1 << 62;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      out_stall = 1'b0;

    // words waiting to be offered, and snapshots waiting to come out
    t_in_word  word_q[$];
    t_out_word snapshot_q[$];

    // predicted statistics
    longint    stat_mean;
    longint    stat_var;
    longint    stat_count;
    t_sample   stat_min;
    t_sample   stat_max;
    t_sample   stat_last;

    // test control
    bit        idle_on = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_served = 1'b0;
    int        hold_left = 0;
    int        send_gap = 0;
    int        rx_gap = 0;
    int        mismatch_count = 0;
    int        quiet_cycles = 0;

    running_mean_variance_minmax u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_word   (in_word),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_out_stall (out_stall)
    );

    always #10 clk = ~clk;

    // statistics back to empty: min at the top, max at the bottom of the sample range
    function automatic void empty_stats();
        stat_mean  = 0;
        stat_var   = 0;
        stat_count = 0;
        stat_min   = SAMPLE_MAX;
        stat_max   = SAMPLE_MIN;
        stat_last  = '0;
    endfunction

    // one welford step on the predicted state, returns the snapshot after the word
    function automatic t_out_word welford_update(t_in_word w);
        t_out_word         snap;
        bit                refused;
        longint            scaled;
        longint            n;
        longint            d1;
        longint            d2;
        longint            m;
        longint            m2;
        longint            v;
        longint unsigned   mag1;
        longint unsigned   mag2;
        logic [127:0]      prod;
        refused = 1'b0;
        if (w.operation == OP_CLEAR) begin
            empty_stats();
        end else if (stat_count >= COUNT_FULL) begin
            // count saturated: word dropped, state untouched
            refused = 1'b1;
        end else begin
            scaled = longint'(w.sample) * (64'sd1 <<< FRAC_BITS);
            n = stat_count + 1;
            d1 = scaled - stat_mean;
            // signed division truncates toward zero
            m = stat_mean + d1 / n;
            if (m > MEAN_HI) m = MEAN_HI;
            if (m < MEAN_LO) m = MEAN_LO;
            stat_mean = m;
            d2 = scaled - m;
            mag1 = (d1 < 0) ? -d1 : d1;
            mag2 = (d2 < 0) ? -d2 : d2;
            // product of magnitudes, fraction dropped, capped
            prod = ({64'd0, mag1} * {64'd0, mag2}) >> FRAC_BITS;
            if (prod > PRODUCT_CAP) prod = PRODUCT_CAP;
            m2 = prod[63:0];
            if ((d1 < 0) != (d2 < 0)) m2 = -m2;
            if (n < 2) begin
                stat_var = 0;
            end else begin
                v = stat_var + (m2 - stat_var) / n;
                if (v < 0) v = 0;
                if (v > VAR_STATE_LIM) v = VAR_STATE_LIM;
                stat_var = v;
            end
            if (w.sample < stat_min) stat_min = w.sample;
            if (w.sample > stat_max) stat_max = w.sample;
            stat_last  = w.sample;
            stat_count = n;
        end
        snap.empty_res      = (stat_count == 0);
        snap.refused        = refused;
        snap.sample_count   = COUNT_BITS'(stat_count);
        snap.mean_value     = MEAN_W'(stat_mean);
        snap.variance_value = (stat_var > VAR_OUT_LIM) ? '1 : VAR_OUT_W'(stat_var);
        snap.minimum        = stat_min;
        snap.maximum        = stat_max;
        snap.last_sample    = stat_last;
        return snap;
    endfunction

    function automatic t_in_word make_word(logic op, t_sample s);
        t_in_word w;
        w.operation = op;
        w.sample    = s;
        return w;
    endfunction

    // compare one field, report the first few mismatches
    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch %0d, %s: expected %h, got %h", mismatch_count, name, want, got);
        end
    endfunction

    // runs of adds, each opened by a clear with a junk sample
    task automatic push_sample_runs(int total);
        int      made;
        int      run_len;
        int      mode;
        int      k;
        t_sample center;
        t_sample s;
        made = 0;
        while (made < total) begin
            word_q.push_back(make_word(OP_CLEAR, t_sample'($urandom)));
            made++;
            // mostly short runs, now and then a long one to grow the count
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                   : $urandom_range(1, 40);
            mode    = $urandom_range(0, 3);
            center  = t_sample'($urandom);
            for (k = 0; k < run_len && made < total; k++) begin
                case (mode)
                    0: s = t_sample'($urandom);
                    1: s = center + t_sample'($urandom_range(0, 64)) - t_sample'(32);
                    2: s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
                    default: s = t_sample'($urandom_range(0, 511)) - t_sample'(256);
                endcase
                word_q.push_back(make_word(OP_ADD, s));
                made++;
            end
        end
    endtask

    // wait until every queued word is sent and every snapshot has come out
    task automatic drain();
        while (word_q.size() != 0 || in_valid || snapshot_q.size() != 0)
            @(posedge clk);
    endtask

    // sender: offers words from word_q, predicts each one as it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                snapshot_q.push_back(welford_update(in_word));
            // a stalled word stays put
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_word  <= word_q.pop_front();
                    if (idle_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each taken result against the oldest snapshot, drives stall
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (snapshot_q.size() == 0) begin
                check_field("result word with nothing expected", 64'd0, 64'd1);
            end else begin
                want = snapshot_q.pop_front();
                check_field("empty_res",      want.empty_res,      out_word.empty_res);
                check_field("refused",        want.refused,        out_word.refused);
                check_field("sample_count",   want.sample_count,   out_word.sample_count);
                check_field("mean_value",     want.mean_value,     out_word.mean_value);
                check_field("variance_value", want.variance_value, out_word.variance_value);
                check_field("minimum",        want.minimum,        out_word.minimum);
                check_field("maximum",        want.maximum,        out_word.maximum);
                check_field("last_sample",    want.last_sample,    out_word.last_sample);
            end
        end
        // long hold-off, counted here, so the block backs up onto its input
        if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog: too long with no word taken on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        empty_stats();

        // directed: clear while empty, extremes, a constant run,
        // alternating extremes for a large variance, back-to-back clears
        word_q.push_back(make_word(OP_CLEAR, SAMPLE_MAX));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MAX));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MIN));
        word_q.push_back(make_word(OP_ADD, t_sample'(0)));
        word_q.push_back(make_word(OP_ADD, t_sample'(-1)));
        word_q.push_back(make_word(OP_ADD, t_sample'(1)));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MAX));
        word_q.push_back(make_word(OP_CLEAR, SAMPLE_MIN));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MIN));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MIN));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MAX));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MIN));
        word_q.push_back(make_word(OP_ADD, SAMPLE_MAX));
        word_q.push_back(make_word(OP_CLEAR, t_sample'(16'h5a5a)));
        word_q.push_back(make_word(OP_ADD, t_sample'(100)));
        word_q.push_back(make_word(OP_ADD, t_sample'(100)));
        word_q.push_back(make_word(OP_ADD, t_sample'(100)));
        word_q.push_back(make_word(OP_CLEAR, t_sample'(0)));
        word_q.push_back(make_word(OP_CLEAR, t_sample'(-1)));
        word_q.push_back(make_word(OP_ADD, t_sample'(-1)));
        word_q.push_back(make_word(OP_ADD, t_sample'(16'h5555)));
        word_q.push_back(make_word(OP_ADD, t_sample'(16'haaaa)));

        // hold reset at the start, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // random runs with idling on both sides and one long receiver hold-off
        idle_on = 1'b1;
        push_sample_runs(600);
        hold_req = 1'b1;
        drain();

        push_sample_runs(775);
        drain();

        // closing stretch without idling
        idle_on = 1'b0;
        push_sample_runs(150);
        drain();

        // let anything stray show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && snapshot_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* running_mean_variance_minmax.f */
sv/rmv_pkg.sv
sv/rmv_div.sv
sv/rmv_datapath.sv
sv/rmv_ctrl.sv
sv/running_mean_variance_minmax.sv
test/tb.sv
